FILE: src/assert_macros.svh
// Assertion macros shared by the padder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock, off during reset.
`define HMP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");

// Condition that must never hold.
`define HMP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

FILE: src/hmp_pkg.sv
// Types, constants and helper functions of the hash message padder.
package hmp_pkg;

  localparam int unsigned CountWidth = 61;   // message byte counter, bit length mod 2^64
  localparam logic [7:0]  PadMarker  = 8'h80;
  localparam logic [3:0]  LenWordIdx = 4'd14; // word slot of the low length word (byte 56)

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ZERO,
    S_LEN_LO,
    S_LEN_HI
  } state_e;

  typedef struct packed {
    logic take;         // accept the input word in the datapath
    logic emit_first;   // partial bytes + marker
    logic emit_zero;    // all-zero padding word
    logic emit_len_lo;  // length bits 31:0, byte reversed
    logic emit_len_hi;  // length bits 63:32, byte reversed, final word
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_load;     // output register free or draining this cycle
    logic ptr_at_len;   // next padding slot is the length field
  } dp_status_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

FILE: src/hmp_if.sv
// Valid/ready channels: message bytes in, padded words out.
interface hmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       carries_byte;
  logic       is_last;

  modport source (output valid, msg_byte, carries_byte, is_last, input ready);
  modport sink   (input valid, msg_byte, carries_byte, is_last, output ready);
endinterface

interface hmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_word;

  modport source (output valid, out_word, last_word, input ready);
  modport sink   (input valid, out_word, last_word, output ready);
endinterface

FILE: src/hash_message_padder_512.sv
// Top level of the 512-bit-block hash message padder.
// Message bytes enter one per cycle on msg_i, while no flush runs and the output
// register is free, and leave as 32-bit words of the padded stream on word_o (first
// stream byte in bits 31:24, or 7:0 when swap_words is set; the two length words are
// never swapped). The item marked is_last starts the flush: the controller then holds
// msg_i off while it emits the marker word, the zero words up to byte 56 of the block
// and the two length words, one word per cycle while word_o does not stall, with an
// idle step in S_ZERO on the way into the length words. Word output is registered;
// backpressure on word_o stalls the flush.
// swap_words may be written only while no message is being flushed.
module hash_message_padder_512 (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      swap_words_we_i,
  input  logic      swap_words_i,
  hmp_in_if.sink    msg_i,
  hmp_out_if.source word_o
);

  hmp_pkg::ctrl_cmd_t  cmd;
  hmp_pkg::dp_status_t status;

  hmp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (msg_i.valid),
    .in_is_last_i (msg_i.is_last),
    .in_ready_o   (msg_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  hmp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .swap_words_we_i (swap_words_we_i),
    .swap_words_i    (swap_words_i),
    .msg_byte_i      (msg_i.msg_byte),
    .carries_byte_i  (msg_i.carries_byte),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (word_o.valid),
    .out_ready_i     (word_o.ready),
    .out_word_o      (word_o.out_word),
    .last_word_o     (word_o.last_word)
  );

endmodule

FILE: src/hmp_ctrl.sv
// Padder controller: sequences byte intake and the padding/length flush.
`include "assert_macros.svh"

module hmp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_is_last_i,
  output logic                  in_ready_o,
  input  hmp_pkg::dp_status_t   status_i,
  output hmp_pkg::ctrl_cmd_t    cmd_o
);

  hmp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      hmp_pkg::S_IDLE: begin
        // a byte may complete a word, so the output slot must be free
        in_ready_o = status_i.can_load;
        if (in_valid_i && status_i.can_load) begin
          cmd_o.take = 1'b1;
          if (in_is_last_i) begin
            state_d = hmp_pkg::S_PAD;
          end
        end
      end
      hmp_pkg::S_PAD: begin
        if (status_i.can_load) begin
          cmd_o.emit_first = 1'b1;
          state_d          = hmp_pkg::S_ZERO;
        end
      end
      hmp_pkg::S_ZERO: begin
        if (status_i.ptr_at_len) begin
          state_d = hmp_pkg::S_LEN_LO;
        end else if (status_i.can_load) begin
          cmd_o.emit_zero = 1'b1;
        end
      end
      hmp_pkg::S_LEN_LO: begin
        if (status_i.can_load) begin
          cmd_o.emit_len_lo = 1'b1;
          state_d           = hmp_pkg::S_LEN_HI;
        end
      end
      hmp_pkg::S_LEN_HI: begin
        if (status_i.can_load) begin
          cmd_o.emit_len_hi = 1'b1;
          state_d           = hmp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hmp_pkg::S_IDLE;
      end
    endcase
  end

  `HMP_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0(cmd_o))
  `HMP_ASSERT(a_len_order, clk_i, rst_ni, cmd_o.emit_len_lo |=> (state_q == hmp_pkg::S_LEN_HI))

endmodule

FILE: src/hmp_datapath.sv
// Padder datapath: byte packing, counters, word assembly and output register.
`include "assert_macros.svh"

module hmp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 swap_words_we_i,
  input  logic                 swap_words_i,
  input  logic [7:0]           msg_byte_i,
  input  logic                 carries_byte_i,
  input  hmp_pkg::ctrl_cmd_t   cmd_i,
  output hmp_pkg::dp_status_t  status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          out_word_o,
  output logic                 last_word_o
);

  logic [hmp_pkg::CountWidth-1:0] count_q, count_d;
  logic [23:0] part_q, part_d;
  logic [1:0]  fill_q, fill_d;
  logic [3:0]  ptr_q, ptr_d;
  logic        swap_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic        out_last_q, out_last_d;

  logic        can_load;
  logic        byte_word;
  logic        load_out;
  logic [31:0] first_word;
  logic [31:0] raw_word;
  logic [63:0] bit_len;

  assign can_load   = !out_valid_q || out_ready_i;
  assign byte_word  = cmd_i.take && carries_byte_i && (fill_q == 2'd3);
  assign load_out   = byte_word || cmd_i.emit_first || cmd_i.emit_zero ||
                      cmd_i.emit_len_lo || cmd_i.emit_len_hi;
  assign bit_len    = {count_q, 3'b000};

  assign status_o.can_load   = can_load;
  assign status_o.ptr_at_len = (ptr_q == hmp_pkg::LenWordIdx);

  // pending bytes sit in the low end of part_q, oldest first
  always_comb begin
    case (fill_q)
      2'd0:    first_word = {hmp_pkg::PadMarker, 24'h000000};
      2'd1:    first_word = {part_q[7:0], hmp_pkg::PadMarker, 16'h0000};
      2'd2:    first_word = {part_q[15:0], hmp_pkg::PadMarker, 8'h00};
      default: first_word = {part_q, hmp_pkg::PadMarker};
    endcase
  end

  always_comb begin
    count_d     = count_q;
    part_d      = part_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    raw_word    = '0;

    if (cmd_i.take && carries_byte_i) begin
      count_d = count_q + hmp_pkg::CountWidth'(1);
      if (fill_q == 2'd3) begin
        part_d = '0;
        fill_d = 2'd0;
      end else begin
        part_d = {part_q[15:0], msg_byte_i};
        fill_d = fill_q + 2'd1;
      end
    end

    if (cmd_i.emit_first) begin
      ptr_d = count_q[5:2] + 4'd1;
    end
    if (cmd_i.emit_zero) begin
      ptr_d = ptr_q + 4'd1;
    end

    if (byte_word) begin
      raw_word = {part_q, msg_byte_i};
    end else if (cmd_i.emit_first) begin
      raw_word = first_word;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      out_last_d  = cmd_i.emit_len_hi;
      if (cmd_i.emit_len_lo) begin
        out_word_d = hmp_pkg::swap32(bit_len[31:0]);
      end else if (cmd_i.emit_len_hi) begin
        out_word_d = hmp_pkg::swap32(bit_len[63:32]);
      end else begin
        out_word_d = swap_q ? hmp_pkg::swap32(raw_word) : raw_word;
      end
    end

    // message done: back to a clean state for the next one
    if (cmd_i.emit_len_hi) begin
      count_d = '0;
      part_d  = '0;
      fill_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      part_q      <= '0;
      fill_q      <= 2'd0;
      ptr_q       <= 4'd0;
      swap_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      count_q     <= count_d;
      part_q      <= part_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      if (swap_words_we_i) begin
        swap_q <= swap_words_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign last_word_o = out_last_q;

  `HMP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, load_out && !can_load)
  `HMP_ASSERT(a_last_flag, clk_i, rst_ni, cmd_i.emit_len_hi |=> (out_valid_q && out_last_q))

endmodule

FILE: test/hash_message_padder_512_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench: random and directed messages through the 512-bit hash padder.
module hash_message_padder_512_tb;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 8;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 24;
  localparam int RandomItems   = 450;
  localparam int NumPhases     = 8;
  localparam int LongHold      = 300;
  localparam int NoisePct      = 10;

  typedef struct packed {
    logic [31:0] out_word;
    logic        last_word;
  } padded_word_t;

  // Predicts the padded word stream and checks words against it in order.
  class padded_word_scoreboard;
    bit [60:0]    byte_count;
    bit [23:0]    partial_bytes;
    bit [1:0]     bytes_held;
    bit           swap_mode;
    padded_word_t expected_words[$];
    int unsigned  words_checked;
    int unsigned  messages_padded;
    int unsigned  errors;

    function void push_stream_byte(bit [7:0] b, bit may_swap);
      logic [31:0] w;
      if (bytes_held == 2'd3) begin
        w = {partial_bytes, b};
        if (may_swap && swap_mode) w = {<<8{w}};
        expected_words.push_back('{out_word: w, last_word: 1'b0});
        partial_bytes = '0;
        bytes_held    = '0;
      end else begin
        partial_bytes = {partial_bytes[15:0], b};
        bytes_held++;
      end
    endfunction

    function void note_item(bit [7:0] b, bit has_byte, bit ends_msg);
      bit [63:0]    bit_len;
      bit [5:0]     pos;
      padded_word_t tail;
      if (has_byte) begin
        push_stream_byte(b, 1'b1);
        byte_count++;
      end
      if (!ends_msg) return;
      bit_len = {byte_count, 3'b000};
      pos     = byte_count[5:0];
      push_stream_byte(hmp_pkg::PadMarker, 1'b1);
      pos++;
      while (pos != 6'd56) begin
        push_stream_byte(8'h00, 1'b1);
        pos++;
      end
      // length goes out LSB first and is never swapped
      for (int i = 0; i < 8; i++) push_stream_byte(bit_len[8*i +: 8], 1'b0);
      tail = expected_words.pop_back();
      tail.last_word = 1'b1;
      expected_words.push_back(tail);
      byte_count    = '0;
      partial_bytes = '0;
      bytes_held    = '0;
      messages_padded++;
    endfunction

    function void check_word(logic [31:0] w, logic last);
      padded_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h last_word %b, none pending", $time, w, last);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      words_checked++;
      if (w !== exp_w.out_word) begin
        $display("%0t: out_word mismatch: expected %h, actual %h", $time, exp_w.out_word, w);
        errors++;
      end
      if (last !== exp_w.last_word) begin
        $display("%0t: last_word mismatch: expected %b, actual %b",
                 $time, exp_w.last_word, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic swap_we;
  logic swap_val;

  hmp_in_if  msg_if ();
  hmp_out_if word_if ();

  hash_message_padder_512 u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .swap_words_we_i (swap_we),
    .swap_words_i    (swap_val),
    .msg_i           (msg_if),
    .word_o          (word_if)
  );

  padded_word_scoreboard sb = new;

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_left;
  int random_items;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      word_if.ready <= 1'b0;
      hold_left--;
    end else begin
      word_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && word_if.valid && word_if.ready)
      sb.check_word(word_if.out_word, word_if.last_word);
  end

  always @(posedge clk) begin
    if (!rst_n || (msg_if.valid && msg_if.ready) || (word_if.valid && word_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, WatchdogLimit);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic ends_msg);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk);
    end
    msg_if.valid        <= 1'b1;
    msg_if.msg_byte     <= b;
    msg_if.carries_byte <= has_byte;
    msg_if.is_last      <= ends_msg;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    sb.note_item(b, has_byte, ends_msg);
    @(negedge clk);
  endtask

  // len bytes; ends on the last byte or on a separate end marker
  task automatic send_message(input int len, input bit end_marker, input int noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        random_items++;
      end
      send_item(8'($urandom), 1'b1, !end_marker && (i == len - 1));
      random_items++;
    end
    if (end_marker || len == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      random_items++;
    end
  endtask

  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_swap(input logic value);
    wait_drained();
    swap_we  <= 1'b1;
    swap_val <= value;
    @(negedge clk);
    swap_we <= 1'b0;
    sb.swap_mode = value;
  endtask

  task automatic set_idle_mix(input int mix);
    case (mix)
      0: begin
        sender_idle_pct = 0;  receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 59; receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;  receiver_stall_pct = 59;
      end
      default: begin
        sender_idle_pct = 34; receiver_stall_pct = 34;
      end
    endcase
  endtask

  initial begin
    int len;
    rst_n               = 1'b0;
    swap_we             = 1'b0;
    swap_val            = 1'b0;
    msg_if.valid        = 1'b0;
    msg_if.msg_byte     = '0;
    msg_if.carries_byte = 1'b0;
    msg_if.is_last      = 1'b0;
    word_if.ready       = 1'b0;
    hold_left           = 0;
    random_items        = 0;
    idle_cycles         = 0;
    set_idle_mix(0);
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: marker without end, empty message, single byte
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // end marker after bytes, with a stray marker inside
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // word-aligned end
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'h04, 1'b1, 1'b1);
    write_swap(1'b1);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    send_item(8'h44, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      write_swap(1'(p) ^ 1'(p >> 2));
      set_idle_mix(p % 4);
      if (p == 0) begin
        // output held off while input keeps coming, so the padder backs up
        hold_left = LongHold;
        send_message(130, 1'b0, 0);
      end
      while (random_items < (p + 1) * RandomItems / NumPhases) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
          6, 7, 8:          len = $urandom_range(50, 72);
          default:          len = $urandom_range(100, 140);
        endcase
        send_message(len, $urandom_range(0, 3) == 0, NoisePct);
      end
    end

    wait_drained();
    $display("Covered %0d padded messages, %0d words checked, random message items %0d,",
             sb.messages_padded, sb.words_checked, random_items);
    $display("both swap_words settings, four idle mixes and a long output hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: hash_message_padder_512.f
+incdir+src
src/hmp_pkg.sv
src/hmp_if.sv
src/hmp_ctrl.sv
src/hmp_datapath.sv
src/hash_message_padder_512.sv
test/hash_message_padder_512_tb.sv
